/* rtl/fbpa_pkg.sv */
// Shared types and codes for the fixed block pool allocator.
package fbpa_pkg;

    // Operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OOM   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE = 1'd1;

    localparam logic [8:0]  BLOCK_COUNT_RST = 9'd256;
    localparam logic [15:0] OBJECT_SIZE_RST = 16'd4;
    localparam logic [23:0] BYTES_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] free_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  given_index;
        logic [8:0]  live_count;
        logic [23:0] used_bytes;
    } rsp_t;

    // Result fields passed from the controller to the output stage
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] given_index;
    } res_t;

endpackage

/* rtl/fbpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/fbpa_ctrl.sv */
// Free-list controller: head pointer, live count, relink sweep and result staging.
module fbpa_ctrl import fbpa_pkg::*; #(
    parameter int POOL_DEPTH = 256,
    localparam int IDX_W  = $clog2(POOL_DEPTH),
    localparam int LINK_W = IDX_W + 1,
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req_data,
    input  logic [8:0]        block_count,
    input  logic              res_ready,
    output logic              res_valid,
    output res_t              res_data,
    output logic [CNT_W-1:0]  res_count,
    output logic              mem_we,
    output logic [IDX_W-1:0]  mem_waddr,
    output logic [LINK_W-1:0] mem_wdata,
    output logic [IDX_W-1:0]  mem_raddr,
    input  logic [LINK_W-1:0] mem_rdata
);

    localparam int EW = (CNT_W > 9) ? CNT_W : 9;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(POOL_DEPTH);
    localparam logic [EW-1:0]     RST_EFF   =
        (POOL_DEPTH < 256) ? EW'(POOL_DEPTH) : EW'(256);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ALLOC_RD
    } state_t;

    state_t            state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  sweep_idx_reg, sweep_idx_next;
    logic [EW-1:0]     sweep_n_reg, sweep_n_next;
    logic              res_pend_reg, res_pend_next;
    res_t              res_reg, res_next;
    logic [CNT_W-1:0]  res_count_reg, res_count_next;

    logic [EW-1:0] eff_count;
    logic [EW-1:0] sweep_succ;
    logic          accept;
    logic          res_move;

    // Effective block count: zero acts as one, clipped to the pool depth
    always_comb
    begin
        if (block_count == 9'd0)
        begin
            eff_count = EW'(1);
        end
        else if (EW'(block_count) > EW'(POOL_DEPTH))
        begin
            eff_count = EW'(POOL_DEPTH);
        end
        else
        begin
            eff_count = EW'(block_count);
        end
    end

    assign sweep_succ = EW'(sweep_idx_reg) + EW'(1);
    assign res_move   = res_pend_reg && res_ready;
    assign req_stall  = (state_reg != ST_IDLE) || (res_pend_reg && !res_ready);
    assign accept     = req_valid && !req_stall;
    assign mem_raddr  = IDX_W'(head_reg);
    assign res_valid  = res_pend_reg;
    assign res_data   = res_reg;
    assign res_count  = res_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sweep_idx_next = sweep_idx_reg;
        sweep_n_next   = sweep_n_reg;
        res_pend_next  = res_pend_reg && !res_move;
        res_next       = res_reg;
        res_count_next = res_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = IDX_W'(req_data.free_index);
        mem_wdata      = head_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_idx_reg;
                mem_wdata = (sweep_succ < sweep_n_reg) ? LINK_W'(sweep_succ) : NULL_LINK;
                if (sweep_idx_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.status      = STATUS_OK;
                    res_next.given_index = 8'd0;
                    res_pend_next        = 1'b1;
                    case (req_data.operation)
                        OP_ALLOC:
                        begin
                            if (head_reg == NULL_LINK)
                            begin
                                res_next.status = STATUS_OOM;
                            end
                            else
                            begin
                                // result waits for the link read
                                res_pend_next = 1'b0;
                                state_next    = ST_ALLOC_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (EW'(req_data.free_index) < eff_count)
                            begin
                                mem_we    = 1'b1;
                                head_next = LINK_W'(req_data.free_index);
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                res_next.status = STATUS_RANGE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next      = '0;
                            count_next     = '0;
                            sweep_idx_next = '0;
                            sweep_n_next   = eff_count;
                            state_next     = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                    res_count_next = count_next;
                end
            end

            ST_ALLOC_RD:
            begin
                head_next = mem_rdata;
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                res_next.status      = STATUS_OK;
                res_next.given_index = 8'(head_reg);
                res_count_next       = count_next;
                res_pend_next        = 1'b1;
                state_next           = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            head_reg      <= '0;
            count_reg     <= '0;
            sweep_idx_reg <= '0;
            sweep_n_reg   <= RST_EFF;
            res_pend_reg  <= 1'b0;
            res_reg       <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sweep_idx_reg <= sweep_idx_next;
            sweep_n_reg   <= sweep_n_next;
            res_pend_reg  <= res_pend_next;
            res_reg       <= res_next;
            res_count_reg <= res_count_next;
        end
    end

endmodule

/* rtl/fbpa_out.sv */
// Output register: byte figure, saturation and response handshake.
module fbpa_out import fbpa_pkg::*; #(
    parameter int CNT_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    output logic             res_ready,
    input  res_t             res_data,
    input  logic [CNT_W-1:0] res_count,
    input  logic [15:0]      object_size,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp_data
);

    localparam int PW = CNT_W + 16;
    localparam int BW = (PW > 24) ? PW : 24;

    logic          valid_reg, valid_next;
    rsp_t          data_reg, data_next;
    logic [BW-1:0] product;

    assign res_ready = !valid_reg || !rsp_stall;
    assign product   = BW'(res_count) * BW'(object_size);

    always_comb
    begin
        valid_next = valid_reg && rsp_stall;
        data_next  = data_reg;
        if (res_valid && res_ready)
        begin
            valid_next             = 1'b1;
            data_next.status       = res_data.status;
            data_next.given_index  = res_data.given_index;
            data_next.live_count   = 9'(res_count);
            data_next.used_bytes   = (product > BW'(BYTES_MAX)) ? BYTES_MAX : 24'(product);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            data_reg  <= data_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule

/* rtl/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator.
//
// Requests arrive on req_* (valid/stall): operation 0 allocates a block,
// 1 returns free_index to the pool, 2 clears and relinks every block.
// Each request produces exactly one response on rsp_* with status, the
// allocated index, the live count and the bytes in use.
// Free, unused codes and allocate on an empty pool complete from the idle
// state; other allocates wait for the registered link memory read of the
// free-list head, and clear runs the relink sweep (one link written a cycle).
// Each result is staged in the controller's result register and then in the
// output register; a clear's response does not wait for the sweep.
// After reset the link memory is relinked by the same sweep with req_stall
// high; configuration writes are taken throughout. A stalled response sits
// in the output register while one further result is staged; besides the
// sweep and the link read, the request side stalls only once both are full.
// Configuration: cfg_we/cfg_index/cfg_wdata write block_count (index 0)
// or object_size (index 1); write only while the block is idle.
// block_count takes effect for the range check at once, and for the list
// layout at the next clear; reset restores the reset value.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int POOL_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

    logic [8:0]  block_count_reg, block_count_next;
    logic [15:0] object_size_reg, object_size_next;

    // controller to output stage
    logic             res_valid;
    logic             res_ready;
    res_t             res_data;
    logic [CNT_W-1:0] res_count;

    // link memory port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [LINK_W-1:0] mem_rdata;

    // Configuration registers
    always_comb
    begin
        block_count_next = block_count_reg;
        object_size_next = object_size_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_COUNT: block_count_next = cfg_wdata[8:0];
                REG_OBJECT_SIZE: object_size_next = cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
            object_size_reg <= OBJECT_SIZE_RST;
        end
        else
        begin
            block_count_reg <= block_count_next;
            object_size_reg <= object_size_next;
        end
    end

    // Free-list head, live count and relink sweep
    fbpa_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .block_count (block_count_reg),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .res_count   (res_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // Next-link table: one link per block, null code is POOL_DEPTH
    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Byte figure and response register
    fbpa_out #(
        .CNT_W (CNT_W)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .res_count   (res_count),
        .object_size (object_size_reg),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data)
    );

endmodule

/* rtl/fbpa_checker.sv */
// Port-level assertions for the fixed block pool allocator, bound to the top level.
module fbpa_checker import fbpa_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_stall,
    input req_t                  req_data,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input rsp_t                  rsp_data
);

    // A stalled response is held
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response dropped or changed while stalled");

    // The relink sweep after reset holds off requests
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> req_stall)
        else $error("request taken during post-reset sweep");

    // A clear starts the relink sweep
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.operation == OP_CLEAR |=> req_stall)
        else $error("request taken straight after clear");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the fixed block pool allocator, with a mirror of the free list.
module testbench;
    import fbpa_pkg::*;

    // Pool geometry and timing used by the testbench
    localparam int         DEPTH         = 256;
    localparam logic [8:0] NULL_PTR      = 9'd256;
    localparam logic [1:0] OP_UNUSED     = 2'd3;   // code with no operation behind it
    localparam int         CLK_HIGH      = 6;
    localparam int         CLK_LOW       = 6;
    localparam int         RESET_CYCLES  = 11;
    localparam int         SETTLE_CYCLES = 8;      // wait after the last reply is back
    localparam int         PHASES        = 14;
    localparam int         PHASE_ITEMS   = 105;
    localparam longint     RUN_LIMIT_NS  = 64'd60_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fixed_block_pool_allocator #(.POOL_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #(CLK_LOW)  clk = 1'b1;
        #(CLK_HIGH) clk = 1'b0;
    end

    // Mirror of the pool: link store, list head, live count and both registers
    logic [8:0]  mirror_link [DEPTH];
    logic [8:0]  mirror_head;
    logic [8:0]  mirror_live;
    logic [8:0]  reg_blocks;
    logic [15:0] reg_obj_size;

    rsp_t owed_replies [$];   // replies predicted at each request transfer, oldest first
    int   held_blocks  [$];   // blocks handed out and not yet returned, to build sane frees
    int   error_count  = 0;
    bit   sender_gaps  = 1'b1;
    bit   sink_stalls  = 1'b1;
    int   stall_left   = 0;

    // Block count as the range check sees it: 0 acts as 1, above the depth acts as the depth
    function automatic int usable_blocks();
        if (reg_blocks == 9'd0)
            return 1;
        if (reg_blocks > DEPTH)
            return DEPTH;
        return int'(reg_blocks);
    endfunction

    // Relink 0..n-1 in order, rest null, head at zero, nothing live
    function automatic void relink_mirror();
        int n;
        n = usable_blocks();
        for (int i = 0; i < DEPTH; i++)
            mirror_link[i] = (i + 1 < n) ? 9'(i + 1) : NULL_PTR;
        mirror_head = '0;
        mirror_live = '0;
    endfunction

    // Apply one operation to the mirror and return the reply it must produce
    function automatic rsp_t run_pool_op(input req_t op_item);
        rsp_t        reply;
        logic [63:0] bytes;
        reply = '0;
        case (op_item.operation)
            OP_ALLOC:
            begin
                if (mirror_head >= NULL_PTR)
                    reply.status = STATUS_OOM;
                else
                begin
                    reply.given_index = mirror_head[7:0];
                    mirror_head = mirror_link[mirror_head[7:0]];
                    if (mirror_live < DEPTH)
                        mirror_live = mirror_live + 9'd1;
                end
            end
            OP_FREE:
            begin
                // no double-free detection: the block is pushed whatever its history
                if (op_item.free_index >= usable_blocks())
                    reply.status = STATUS_RANGE;
                else
                begin
                    mirror_link[op_item.free_index] = mirror_head;
                    mirror_head = {1'b0, op_item.free_index};
                    if (mirror_live > 0)
                        mirror_live = mirror_live - 9'd1;
                end
            end
            OP_CLEAR:
                relink_mirror();
            default:
                ;
        endcase
        bytes = 64'(mirror_live) * 64'(reg_obj_size);
        reply.live_count = mirror_live;
        reply.used_bytes = (bytes > 64'(BYTES_MAX)) ? BYTES_MAX : bytes[23:0];
        return reply;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    task automatic check_reply(input rsp_t got);
        rsp_t want;
        if (owed_replies.size() == 0)
        begin
            $display("%0t: reply with nothing outstanding, expected none actual %h",
                     $time, got);
            error_count++;
        end
        else
        begin
            want = owed_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("given_index", 32'(want.given_index), 32'(got.given_index));
            compare_field("live_count", 32'(want.live_count), 32'(got.live_count));
            compare_field("used_bytes", 32'(want.used_bytes), 32'(got.used_bytes));
        end
    endtask

    // Reply side: check every transfer, then decide the stall for the next cycle.
    // rsp_stall read here is the value the block saw at this edge.
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            check_reply(rsp_data);
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (sink_stalls && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
        end
    end

    // Offer one request, hold it until transfer, predict its reply at the transfer.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_op(input logic [1:0] opcode, input logic [7:0] index);
        req_t item;
        rsp_t reply;
        int   gap;
        item.operation  = opcode;
        item.free_index = index;
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        reply = run_pool_op(item);
        owed_replies.push_back(reply);
        if (opcode == OP_ALLOC && reply.status == STATUS_OK)
            held_blocks.push_back(int'(reply.given_index));
        if (opcode == OP_CLEAR)
            held_blocks.delete();
        gap = sender_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted reply is back, then let the pipe empty
    task automatic settle();
        req_valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; always called after settle(), though a relink sweep may still run
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        if (index == REG_BLOCK_COUNT)
            reg_blocks = data[8:0];
        else
            reg_obj_size = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Fresh pool at reset values: first allocations, frees at both ends of the range,
    // the unused code, clear, and a free with nothing live
    task automatic test_after_reset();
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_ALLOC, 8'hFF);     // index ignored on allocate
        send_op(OP_FREE, 8'h00);
        send_op(OP_FREE, 8'hFF);      // top of a full-size pool is in range
        send_op(OP_UNUSED, 8'hFF);
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_CLEAR, 8'hAA);
        send_op(OP_FREE, 8'h07);      // pushed, count stays at zero
        send_op(OP_ALLOC, 8'h55);
    endtask

    // Two blocks, largest object: exhaust the pool, free outside it, recover
    task automatic test_small_pool();
        settle();
        write_reg(REG_BLOCK_COUNT, 16'd2);
        write_reg(REG_OBJECT_SIZE, 16'hFFFF);
        send_op(OP_CLEAR, 8'h00);
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_ALLOC, 8'h00);     // out of memory
        send_op(OP_FREE, 8'h02);      // just past the end
        send_op(OP_FREE, 8'hFF);
        send_op(OP_FREE, 8'h01);
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_UNUSED, 8'h00);
    endtask

    // Block count of zero acts as one, and the range check follows the write at once
    // while the old layout stays until a clear; then an over-range count with upper
    // data bits set, and a zero object size
    task automatic test_count_edges();
        settle();
        write_reg(REG_BLOCK_COUNT, 16'd0);
        send_op(OP_FREE, 8'h01);      // outside a one-block pool
        send_op(OP_FREE, 8'h00);
        send_op(OP_CLEAR, 8'h00);
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_ALLOC, 8'h00);     // out of memory
        settle();
        write_reg(REG_BLOCK_COUNT, 16'hFFFF);
        write_reg(REG_OBJECT_SIZE, 16'h0000);
        send_op(OP_CLEAR, 8'h00);
        send_op(OP_FREE, 8'hFF);
        send_op(OP_ALLOC, 8'h00);
    endtask

    // Freeing block 0 with nothing live links it to itself, so allocation never runs
    // dry and the live count climbs to the depth and saturates there. No idling here.
    task automatic test_count_saturation();
        settle();
        write_reg(REG_BLOCK_COUNT, 16'd256);
        write_reg(REG_OBJECT_SIZE, 16'hFFFF);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        send_op(OP_CLEAR, 8'h00);
        send_op(OP_FREE, 8'h00);
        repeat (DEPTH + 4) send_op(OP_ALLOC, 8'h00);
        send_op(OP_CLEAR, 8'h00);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    function automatic logic [8:0] pick_block_count();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 7)
            return 9'($urandom_range(1, 8));
        if (roll < 12)
            return 9'($urandom_range(9, 40));
        if (roll < 14)
            return 9'($urandom_range(41, 254));
        if (roll < 16)
            return 9'd256;
        if (roll == 16)
            return 9'd255;
        if (roll == 17)
            return 9'd0;
        return 9'($urandom_range(257, 511));
    endfunction

    function automatic logic [15:0] pick_object_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 16'd4;
        if (roll < 4)
            return 16'hFFFF;
        if (roll == 4)
            return 16'($urandom_range(0, 3));
        return 16'($urandom_range(4, 65535));
    endfunction

    // One random operation; frees mostly return a block still held so the list stays
    // well formed, with some out-of-range and some arbitrary (double) frees mixed in
    task automatic random_op(input int alloc_pct);
        int         roll;
        int         pick;
        logic [7:0] index;
        roll  = $urandom_range(0, 99);
        index = 8'($urandom);
        if (roll < 2)
            send_op(OP_CLEAR, index);
        else if (roll < 4)
            send_op(OP_UNUSED, index);
        else if (roll < 4 + alloc_pct * 96 / 100)
            send_op(OP_ALLOC, index);
        else
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0 && usable_blocks() < DEPTH)
                index = 8'($urandom_range(usable_blocks(), DEPTH - 1));
            else if (roll >= 2 && held_blocks.size() != 0)
            begin
                pick  = $urandom_range(0, held_blocks.size() - 1);
                index = 8'(held_blocks[pick]);
                held_blocks.delete(pick);
            end
            send_op(OP_FREE, index);
        end
    endtask

    // Phases of random traffic, each under its own register setting; the first uses
    // the smallest pool and the last the full one. Allocate/free bias shifts every
    // twenty items so the list both drains and refills.
    task automatic test_random_traffic();
        int         mix;
        logic [8:0] blocks;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == 0)
                blocks = 9'd1;
            else if (phase == PHASES - 1)
                blocks = 9'd256;
            else
                blocks = pick_block_count();
            write_reg(REG_BLOCK_COUNT, {7'($urandom), blocks});
            if (phase == 0 || $urandom_range(0, 1) == 0)
                write_reg(REG_OBJECT_SIZE, pick_object_size());
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            // usually start from a relinked list; otherwise the old layout carries on
            if ($urandom_range(0, 4) != 0)
                send_op(OP_CLEAR, 8'($urandom));
            mix = 50;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 20 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       mix = 80;
                        1:       mix = 20;
                        2:       mix = 50;
                        default: mix = $urandom_range(0, 100);
                    endcase
                end
                // sender holds off until every reply is home
                if (n == PHASE_ITEMS / 2 && phase % 4 == 0)
                    settle();
                random_op(mix);
            end
        end
    endtask

    initial
    begin
        reg_blocks   = BLOCK_COUNT_RST;
        reg_obj_size = OBJECT_SIZE_RST;
        relink_mirror();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // the block relinks after reset with req_stall high; send_op waits it out
        test_after_reset();
        test_small_pool();
        test_count_edges();
        test_count_saturation();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

/* fixed_block_pool_allocator.f */
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_out.sv
rtl/fixed_block_pool_allocator.sv
rtl/fbpa_checker.sv
tb/testbench.sv
